[rtl/hce_pkg.sv]
package hce_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PKT_BYTES  = 26;
	localparam int unsigned WORD_BITS  = 26;
	localparam int unsigned PAR_BYTES  = 5;
	localparam int unsigned PAR_W      = 5;
	localparam int unsigned STORE_W    = PAR_W * 8;
	localparam int unsigned CNT_W      = $clog2(PKT_BYTES);
	localparam int unsigned BIW_W      = $clog2(WORD_BITS);
	localparam int unsigned BURST_W    = $clog2(PAR_BYTES + 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PAR_W-1:0]  par_t;
	typedef logic [BIW_W-1:0]  biw_t;

	// outcome of folding one byte into the running word
	typedef struct packed {
		logic word_done;
		biw_t biw;
		par_t wp;
		par_t fin_par;
	} step_res_t;

	// codeword position of data bit k of a word (skips the power-of-two slots)
	function automatic par_t data_pos(input biw_t k);
		par_t p;
		if (k == '0)
			p = par_t'(3);
		else if (k <= biw_t'(3))
			p = par_t'(k) + par_t'(4);
		else if (k <= biw_t'(10))
			p = par_t'(k) + par_t'(5);
		else
			p = par_t'(k) + par_t'(6);
		return p;
	endfunction

endpackage

[rtl/hce_step.sv]
module hce_step (
	input  hce_pkg::byte_t     data,
	input  hce_pkg::biw_t      biw,
	input  hce_pkg::par_t      wp,
	output hce_pkg::step_res_t res
);
	import hce_pkg::*;

	localparam int unsigned IDX_W = BIW_W + 1;

	par_t acc_old;
	par_t acc_new;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] nxt;

	// each bit's position is independent: bits at or below slot 25 close the
	// current word, the rest open the next one
	always_comb begin
		acc_old = '0;
		acc_new = '0;
		idx     = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			idx = {1'b0, biw} + IDX_W'(i);
			if (data[BYTE_W-1-i]) begin
				if (idx >= IDX_W'(WORD_BITS))
					acc_new = acc_new ^ data_pos(biw_t'(idx - IDX_W'(WORD_BITS)));
				else
					acc_old = acc_old ^ data_pos(biw_t'(idx));
			end
		end
	end

	assign nxt = {1'b0, biw} + IDX_W'(BYTE_W);

	always_comb begin
		res.fin_par = wp ^ acc_old;
		if (nxt >= IDX_W'(WORD_BITS)) begin
			res.word_done = 1'b1;
			res.biw       = biw_t'(nxt - IDX_W'(WORD_BITS));
			res.wp        = acc_new;
		end else begin
			res.word_done = 1'b0;
			res.biw       = biw_t'(nxt);
			res.wp        = wp ^ acc_old;
		end
	end

endmodule

[rtl/hamming_31_26_packet_encoder_core.sv]
// channel | direction | handshake           | payload
// in      | sink      | in_valid, in_ready   | data_byte
// out     | source    | out_valid, out_ready | out_byte, is_parity, last
//
// One input word is registered in byte_s1, folded into the parity state and
// moved on to the output register: one word per cycle while out_ready holds
// and no parity burst runs. The 26th word of a packet is followed by five parity
// words drawn from the 40-bit store; input stalls meanwhile (31 out per 26 in).
// arst_n clears the pipeline valids, the counters and the word parity.
// A stalled output holds its word; the input stage fills behind it.
module hamming_31_26_packet_encoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hce_pkg::byte_t data_byte,
	output logic           out_valid,
	input  logic           out_ready,
	output hce_pkg::byte_t out_byte,
	output logic           is_parity,
	output logic           last
);
	import hce_pkg::*;

	logic                 valid_s1;
	byte_t                byte_s1;
	logic                 out_valid_q;
	byte_t                out_byte_q;
	logic                 is_parity_q;
	logic                 last_q;
	par_t                 wp_q;
	biw_t                 biw_q;
	logic [STORE_W-1:0]   store_q;
	logic [CNT_W-1:0]     count_q;
	logic [BURST_W-1:0]   burst_q;

	logic      out_free;
	logic      burst_on;
	logic      adv_s1;
	logic      pkt_end;
	byte_t     par_byte;
	step_res_t st;

	hce_step u_step (
		.data (byte_s1),
		.biw  (biw_q),
		.wp   (wp_q),
		.res  (st)
	);

	assign out_free = !out_valid_q || out_ready;
	assign burst_on = burst_q != '0;
	assign adv_s1   = valid_s1 && out_free && !burst_on;
	assign in_ready = !valid_s1 || adv_s1;
	assign pkt_end  = count_q == CNT_W'(PKT_BYTES - 1);

	// burst counts down from five; the first parity word is the top of the store
	always_comb begin
		case (burst_q)
			BURST_W'(5): par_byte = store_q[39:32];
			BURST_W'(4): par_byte = store_q[31:24];
			BURST_W'(3): par_byte = store_q[23:16];
			BURST_W'(2): par_byte = store_q[15:8];
			default:     par_byte = store_q[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			biw_q       <= '0;
			count_q     <= '0;
			burst_q     <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (out_free)
				out_valid_q <= burst_on || valid_s1;
			if (out_free && burst_on)
				burst_q <= burst_q - BURST_W'(1);
			if (adv_s1) begin
				wp_q  <= st.wp;
				biw_q <= st.biw;
				if (pkt_end) begin
					count_q <= '0;
					burst_q <= BURST_W'(PAR_BYTES);
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// every packet shifts in all eight words, so the store needs no clearing
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= data_byte;
		if (adv_s1 && st.word_done)
			store_q <= {store_q[STORE_W-PAR_W-1:0],
				st.fin_par[0], st.fin_par[1], st.fin_par[2], st.fin_par[3], st.fin_par[4]};
		if (out_free) begin
			if (burst_on) begin
				out_byte_q  <= par_byte;
				is_parity_q <= 1'b1;
				last_q      <= burst_q == BURST_W'(1);
			end else begin
				out_byte_q  <= byte_s1;
				is_parity_q <= 1'b0;
				last_q      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_parity = is_parity_q;
	assign last      = last_q;

endmodule

[rtl/hce_checker.sv]
module hce_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input hce_pkg::byte_t data_byte,
	input logic           out_valid,
	input logic           out_ready,
	input hce_pkg::byte_t out_byte,
	input logic           is_parity,
	input logic           last
);
	import hce_pkg::*;

	// an offered input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte))
		else $error("input word changed while waiting");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(is_parity) && $stable(last))
		else $error("output word changed while stalled");

	a_last_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> is_parity)
		else $error("last on a data word");

	// parity words come as an unbroken burst
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && is_parity && !last |=> out_valid && is_parity)
		else $error("parity burst broken");

	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !(out_valid && is_parity))
		else $error("parity word after end of packet");

endmodule

bind hamming_31_26_packet_encoder_core hce_checker u_hce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.data_byte (data_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.is_parity (is_parity),
	.last      (last)
);
